// ===== design/pfa_pkg.sv =====
`timescale 1ns / 1ps
package pfa_pkg;

  localparam int NUM_PARTS = 16;
  localparam int SIZE_BITS = 16;
  localparam int IDX_W     = $clog2(NUM_PARTS);
  localparam int CNT_W     = $clog2(NUM_PARTS + 1);
  localparam int SUM_W     = 20;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 5;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    POL_BEST  = 2'd0,
    POL_FIRST = 2'd1,
    POL_WORST = 2'd2,
    POL_NEXT  = 2'd3
  } fit_policy_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_FINISH
  } pfa_state_t;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  part_index;
    logic [15:0] req_size;
  } in_word_t;

  typedef struct packed {
    logic        granted;
    logic [3:0]  granted_index;
    logic [15:0] leftover;
    logic [19:0] internal_frag_total;
    logic [19:0] free_total;
    logic        external_frag;
    logic        external_frag_seen;
  } out_word_t;

  typedef struct packed {
    logic                 size_we;
    logic                 used_we;
    logic [IDX_W-1:0]     wr_index;
    logic [SIZE_BITS-1:0] wr_size;
  } tbl_cmd_t;

  typedef struct packed {
    logic                 fits;
    logic                 take;
    logic [SIZE_BITS-1:0] leftover;
  } fit_res_t;

endpackage

// ===== design/pfa_table.sv =====
`timescale 1ns / 1ps
module pfa_table
  import pfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  tbl_cmd_t             cmd,
  input  logic [IDX_W-1:0]     rd_index,
  output logic [SIZE_BITS-1:0] rd_size,
  output logic                 rd_used
);

  logic [SIZE_BITS-1:0] part_size_r [NUM_PARTS];
  logic [NUM_PARTS-1:0] part_used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PARTS; i++) begin
        part_size_r[i] <= '0;
      end
      part_used_r <= '0;
    end else begin
      if (cmd.size_we) begin
        part_size_r[cmd.wr_index] <= cmd.wr_size;
      end
      if (cmd.used_we) begin
        part_used_r[cmd.wr_index] <= 1'b1;
      end
    end
  end

  assign rd_size = part_size_r[rd_index];
  assign rd_used = part_used_r[rd_index];

endmodule

// ===== design/pfa_fit_unit.sv =====
`timescale 1ns / 1ps
module pfa_fit_unit
  import pfa_pkg::*;
(
  input  fit_policy_t          policy,
  input  logic [SIZE_BITS-1:0] entry_size,
  input  logic                 entry_used,
  input  logic [SIZE_BITS-1:0] req_size,
  input  logic                 have_pick,
  input  logic [SIZE_BITS-1:0] pick_left,
  output fit_res_t             res
);

  logic [SIZE_BITS-1:0] diff;
  logic                 fits;
  logic                 better;

  assign diff = entry_size - req_size;
  assign fits = !entry_used && (entry_size >= req_size);

  always_comb begin
    case (policy)
      POL_BEST:  better = diff < pick_left;
      POL_WORST: better = diff > pick_left;
      default:   better = 1'b0;
    endcase
  end

  assign res.fits     = fits;
  assign res.take     = fits && (!have_pick || better);
  assign res.leftover = diff;

endmodule

// ===== design/partition_fit_allocator_unit.sv =====
`timescale 1ns / 1ps
// channel  ports                                 direction  word
// input    in_valid, in_stall, in_data           in         in_word_t
// result   out_valid, out_stall, out_data        out        out_word_t
// config   cfg_valid, cfg_ready, cfg_index/data  in         policy, scan count
//
// load: accepted in ST_IDLE, written to the table on commit in ST_FINISH
// allocate: accepted in ST_IDLE, then the partition scan in ST_SCAN (n = scan count, one entry a cycle
//   through the shared fit unit), then commit in ST_FINISH; next fit first reduces its start in ST_MOD
// first and next fit stop at the first fitting entry
// reset is synchronous; the table clears in the reset cycle itself
// the result register holds a word under out_stall; commit waits for it to drain
module partition_fit_allocator_unit
  import pfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  pfa_state_t           state_r, state_nxt;
  in_word_t             req_r, req_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [SIZE_BITS-1:0] pick_left_r, pick_left_nxt;
  logic [IDX_W-1:0]     next_start_r, next_start_nxt;
  logic [SUM_W-1:0]     frag_sum_r, frag_sum_nxt;
  logic [SUM_W-1:0]     free_sum_r, free_sum_nxt;
  logic                 ext_seen_r, ext_seen_nxt;
  fit_policy_t          policy_r;
  logic [CFG_DAT_W-1:0] blocks_r;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_data_r, out_data_nxt;

  tbl_cmd_t             tbl_cmd;
  logic [SIZE_BITS-1:0] rd_size;
  logic                 rd_used;
  fit_res_t             fit;
  logic [CNT_W-1:0]     n_calc;
  logic [SUM_W:0]       free_add;
  logic [SUM_W:0]       frag_add;
  logic                 ext_flag;
  logic                 commit;

  pfa_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (tbl_cmd),
    .rd_index (pos_r),
    .rd_size  (rd_size),
    .rd_used  (rd_used)
  );

  pfa_fit_unit u_fit (
    .policy     (policy_r),
    .entry_size (rd_size),
    .entry_used (rd_used),
    .req_size   (req_r.req_size),
    .have_pick  (found_r),
    .pick_left  (pick_left_r),
    .res        (fit)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign n_calc   = (blocks_r > CFG_DAT_W'(NUM_PARTS)) ? CNT_W'(NUM_PARTS)
                                                        : CNT_W'(blocks_r);
  assign free_add = {1'b0, free_sum_r} + (SUM_W + 1)'(req_r.req_size);
  assign frag_add = {1'b0, frag_sum_r} + (SUM_W + 1)'(pick_left_r);
  assign ext_flag = free_sum_r > SUM_W'(req_r.req_size);
  assign commit   = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_BEST;
      blocks_r <= CFG_DAT_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIT_POLICY:    policy_r <= fit_policy_t'(cfg_data[1:0]);
        CFG_BLOCKS_IN_USE: blocks_r <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      found_r      <= 1'b0;
      next_start_r <= '0;
      frag_sum_r   <= '0;
      free_sum_r   <= '0;
      ext_seen_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      found_r      <= found_nxt;
      next_start_r <= next_start_nxt;
      frag_sum_r   <= frag_sum_nxt;
      free_sum_r   <= free_sum_nxt;
      ext_seen_r   <= ext_seen_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    n_r         <= n_nxt;
    cnt_r       <= cnt_nxt;
    pos_r       <= pos_nxt;
    pick_r      <= pick_nxt;
    pick_left_r <= pick_left_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    n_nxt          = n_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    pick_nxt       = pick_r;
    pick_left_nxt  = pick_left_r;
    next_start_nxt = next_start_r;
    frag_sum_nxt   = frag_sum_r;
    free_sum_nxt   = free_sum_r;
    ext_seen_nxt   = ext_seen_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    tbl_cmd        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          found_nxt = 1'b0;
          cnt_nxt   = '0;
          n_nxt     = n_calc;
          pos_nxt   = '0;
          if (in_data.req_type == REQ_LOAD || n_calc == '0) begin
            state_nxt = ST_FINISH;
          end else if (policy_r == POL_NEXT) begin
            pos_nxt   = next_start_r;
            state_nxt = ST_MOD;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      // next fit start: reduce next_start modulo the scan count
      ST_MOD: begin
        if (CNT_W'(pos_r) >= n_r) begin
          pos_nxt = IDX_W'(CNT_W'(pos_r) - n_r);
        end else begin
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (fit.take) begin
          found_nxt     = 1'b1;
          pick_nxt      = pos_r;
          pick_left_nxt = fit.leftover;
        end
        cnt_nxt = cnt_r + 1'b1;
        pos_nxt = (CNT_W'(pos_r) + 1'b1 == n_r) ? '0 : pos_r + 1'b1;
        if ((cnt_r + 1'b1 == n_r) ||
            (fit.fits && (policy_r == POL_FIRST || policy_r == POL_NEXT))) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (commit) begin
          out_data_nxt = '0;
          if (req_r.req_type == REQ_LOAD) begin
            tbl_cmd.size_we  = 1'b1;
            tbl_cmd.wr_index = IDX_W'(req_r.part_index);
            tbl_cmd.wr_size  = req_r.req_size;
            free_sum_nxt     = free_add[SUM_W] ? SUM_MAX : free_add[SUM_W-1:0];
          end else if (found_r) begin
            tbl_cmd.used_we  = 1'b1;
            tbl_cmd.wr_index = pick_r;
            frag_sum_nxt     = frag_add[SUM_W] ? SUM_MAX : frag_add[SUM_W-1:0];
            free_sum_nxt     = ext_flag ? free_sum_r - SUM_W'(req_r.req_size) : '0;
            if (policy_r == POL_NEXT) begin
              next_start_nxt = (CNT_W'(pick_r) + 1'b1 == n_r) ? '0 : pick_r + 1'b1;
            end
            out_data_nxt.granted       = 1'b1;
            out_data_nxt.granted_index = 4'(pick_r);
            out_data_nxt.leftover      = 16'(pick_left_r);
          end else begin
            ext_seen_nxt               = ext_seen_r | ext_flag;
            out_data_nxt.external_frag = ext_flag;
          end
          out_data_nxt.internal_frag_total = frag_sum_nxt;
          out_data_nxt.free_total          = free_sum_nxt;
          out_data_nxt.external_frag_seen  = ext_seen_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_word_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result word appeared without a commit");

  a_refusal_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.granted) |->
      (out_data_r.granted_index == '0 && out_data_r.leftover == '0))
    else $error("refused request carries a partition");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (CNT_W'(pos_r) < n_r && cnt_r < n_r))
    else $error("scan position outside scanned range");

  a_ext_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.external_frag) |-> out_data_r.external_frag_seen)
    else $error("external fragmentation not recorded");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_data_r))
    else $error("held result word overwritten");

endmodule

// ===== test/partition_fit_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
module partition_fit_allocator_unit_tb;
  import pfa_pkg::*;

  class alloc_scoreboard;
    logic [SIZE_BITS-1:0] size_tab [NUM_PARTS];
    bit                   used_tab [NUM_PARTS];
    logic [IDX_W-1:0]     next_ptr;
    logic [SUM_W-1:0]     frag_acc;
    logic [SUM_W-1:0]     free_acc;
    bit                   ext_sticky;
    fit_policy_t          policy;
    logic [CFG_DAT_W-1:0] scan_cfg;
    out_word_t            expected_q [$];
    int                   errors;

    function new();
      foreach (size_tab[i]) begin
        size_tab[i] = '0;
        used_tab[i] = 1'b0;
      end
      next_ptr   = '0;
      frag_acc   = '0;
      free_acc   = '0;
      ext_sticky = 1'b0;
      policy     = POL_BEST;
      scan_cfg   = 5'd16;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      if (idx == CFG_FIT_POLICY) begin
        policy = fit_policy_t'(val[1:0]);
      end else begin
        scan_cfg = val;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [SIZE_BITS-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + b;
      return (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function void note_input(in_word_t w);
      out_word_t            r;
      int                   n;
      int                   k;
      int                   j;
      int                   start;
      int                   pick;
      bit                   found;
      logic [SIZE_BITS-1:0] pick_left;
      logic [SIZE_BITS-1:0] l;
      r = '0;
      if (w.req_type == REQ_LOAD) begin
        if (w.part_index < NUM_PARTS) begin
          size_tab[w.part_index] = w.req_size;
          free_acc = sat_add(free_acc, w.req_size);
        end
      end else begin
        n = (scan_cfg > NUM_PARTS) ? NUM_PARTS : scan_cfg;
        found = 1'b0;
        pick = 0;
        pick_left = '0;
        if (policy == POL_NEXT) begin
          start = (n != 0) ? (next_ptr % n) : 0;
          for (k = 0; k < n && !found; k++) begin
            j = (start + k) % n;
            if (!used_tab[j] && size_tab[j] >= w.req_size) begin
              found = 1'b1;
              pick = j;
              pick_left = size_tab[j] - w.req_size;
            end
          end
        end else begin
          for (k = 0; k < n; k++) begin
            if (!used_tab[k] && size_tab[k] >= w.req_size &&
                !(policy == POL_FIRST && found)) begin
              l = size_tab[k] - w.req_size;
              if (!found || (policy == POL_BEST && l < pick_left) ||
                  (policy == POL_WORST && l > pick_left)) begin
                found = 1'b1;
                pick = k;
                pick_left = l;
              end
            end
          end
        end
        if (found) begin
          used_tab[pick]  = 1'b1;
          r.granted       = 1'b1;
          r.granted_index = pick[IDX_W-1:0];
          r.leftover      = pick_left;
          frag_acc = sat_add(frag_acc, pick_left);
          free_acc = (free_acc > w.req_size) ? free_acc - w.req_size : '0;
          if (policy == POL_NEXT) next_ptr = IDX_W'((pick + 1) % n);
        end else begin
          r.external_frag = (free_acc > w.req_size);
          ext_sticky = ext_sticky | r.external_frag;
        end
      end
      r.internal_frag_total = frag_acc;
      r.free_total          = free_acc;
      r.external_frag_seen  = ext_sticky;
      expected_q = {expected_q, r};
    endfunction

    function void flag(string what, out_word_t exp, out_word_t got);
      errors++;
      if (errors <= 10) begin
        $display("%s: exp g=%0d idx=%0d left=%0d frag=%0d free=%0d ext=%0d seen=%0d",
                 what, exp.granted, exp.granted_index, exp.leftover,
                 exp.internal_frag_total, exp.free_total, exp.external_frag,
                 exp.external_frag_seen);
        $display("  got g=%0d idx=%0d left=%0d frag=%0d free=%0d ext=%0d seen=%0d",
                 got.granted, got.granted_index, got.leftover,
                 got.internal_frag_total, got.free_total, got.external_frag,
                 got.external_frag_seen);
      end
    endfunction

    function void check(out_word_t got);
      out_word_t exp;
      if (expected_q.size() == 0) begin
        flag("unexpected word", '0, got);
        return;
      end
      exp = expected_q.pop_front();
      if (got.granted !== exp.granted || got.granted_index !== exp.granted_index ||
          got.leftover !== exp.leftover ||
          got.internal_frag_total !== exp.internal_frag_total ||
          got.free_total !== exp.free_total || got.external_frag !== exp.external_frag ||
          got.external_frag_seen !== exp.external_frag_seen) begin
        flag("mismatch", exp, got);
      end
    endfunction

    function void close_out();
      errors += expected_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  alloc_scoreboard sb;
  int send_gap;
  int recv_gap;

  logic [CFG_DAT_W-1:0] scan_choice [12] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd16,
                                            5'd12, 5'd2, 5'd16, 5'd31, 5'd9, 5'd16};

  partition_fit_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_gap);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check(out_data);
  end

  task automatic send_word(in_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(w);
  endtask

  task automatic load_part(logic [3:0] idx, logic [15:0] sz);
    in_word_t w;
    w.req_type   = REQ_LOAD;
    w.part_index = idx;
    w.req_size   = sz;
    send_word(w);
  endtask

  task automatic request(logic [15:0] sz);
    in_word_t w;
    w.req_type   = REQ_ALLOC;
    w.part_index = 4'($urandom);
    w.req_size   = sz;
    send_word(w);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    w.part_index = 4'($urandom);
    pick = $urandom_range(99);
    if ($urandom_range(99) < 30) begin
      w.req_type = REQ_LOAD;
      w.req_size = (pick < 10) ? 16'h0000 : (pick < 20) ? 16'hFFFF : 16'($urandom);
    end else begin
      w.req_type = REQ_ALLOC;
      if (pick < 40) w.req_size = 16'($urandom_range(1023));
      else if (pick < 70) w.req_size = 16'($urandom);
      else if (pick < 85) w.req_size = 16'hFFFF;
      else w.req_size = 16'h0000;
    end
    return w;
  endfunction

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    send_gap  = 8;
    recv_gap  = 74;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_reg(CFG_BLOCKS_IN_USE, 5'd16);
    write_reg(CFG_FIT_POLICY, POL_NEXT);
    // nothing loaded yet, nothing free
    request(16'd1);
    load_part(4'd0, 16'hFFFF);
    load_part(4'd1, 16'd100);
    load_part(4'd2, 16'd50);
    load_part(4'd3, 16'd200);
    load_part(4'd4, 16'd50);
    load_part(4'd5, 16'd0);
    request(16'd150);
    request(16'd150);
    // next fit wraps round a short scan range
    write_reg(CFG_BLOCKS_IN_USE, 5'd5);
    request(16'd60);
    write_reg(CFG_BLOCKS_IN_USE, 5'd16);
    write_reg(CFG_FIT_POLICY, POL_BEST);
    request(16'd0);
    write_reg(CFG_FIT_POLICY, POL_FIRST);
    request(16'd10);
    load_part(4'd6, 16'd80);
    load_part(4'd7, 16'd80);
    load_part(4'd8, 16'd30);
    load_part(4'd15, 16'hFFFF);
    // worst fit, then an exact fit under worst fit
    write_reg(CFG_FIT_POLICY, POL_WORST);
    request(16'd30);
    request(16'd80);
    write_reg(CFG_FIT_POLICY, POL_BEST);
    request(16'd30);
    request(16'hFFFF);
    // empty scan range refuses everything
    write_reg(CFG_BLOCKS_IN_USE, 5'd0);
    request(16'd0);
    write_reg(CFG_BLOCKS_IN_USE, 5'd31);
    write_reg(CFG_FIT_POLICY, POL_NEXT);
    request(16'd20);

    for (int ph = 0; ph < 3; ph++) begin
      send_gap = (ph == 0) ? 8 : (ph == 1) ? 74 : 0;
      recv_gap = (ph == 0) ? 74 : (ph == 1) ? 8 : 0;
      for (int s = 0; s < 4; s++) begin
        write_reg(CFG_FIT_POLICY, CFG_DAT_W'((ph + s) % 4));
        write_reg(CFG_BLOCKS_IN_USE, scan_choice[ph * 4 + s]);
        repeat (46) send_word(random_word());
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
